>>> src/frms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed RMS volume package
// Shared constants and the job tag type passed from the front end through
// the job queue to the back end.
// ----------------------------------------------------------------------------
package frms_pkg;

	// Width of the hop length configuration register.
	localparam int HOP_BITS = 13;
	// Value of the hop length register after reset.
	localparam int HOP_RESET = 512;
	// Smallest effective hop; smaller register values act as this.
	localparam int MIN_HOP = 128;
	// Entries in the job queue between the front and the back end.
	localparam int QUEUE_DEPTH = 8;
	// Jobs one sample can create (magnitude frame plus a closed frame).
	localparam int JOBS_PER_SAMPLE = 2;

	// Tag carried with every job.
	typedef struct packed {
		logic is_frame;  // 1: closed frame (divide and root), 0: magnitude beat
		logic last;      // last result caused by its sample
	} frms_job_tag_t;

	localparam int TAG_BITS = $bits(frms_job_tag_t);

endpackage

>>> src/frms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed RMS volume job queue
// Small register queue that takes up to two jobs per cycle and gives one.
// ----------------------------------------------------------------------------
module frms_queue #(
	parameter int WIDTH = 59,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr0,
	input  logic                       wr1,
	input  logic [WIDTH-1:0]           wr_data0,
	input  logic [WIDTH-1:0]           wr_data1,
	input  logic                       rd,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       nonempty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    wp_nx;
	logic [CW-1:0]    n_wr;

	assign wp_nx    = wp_q + AW'(1);
	assign n_wr     = CW'(wr0) + CW'(wr1);
	assign rd_data  = mem_q[rp_q];
	assign nonempty = (cnt_q != '0);
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[wp_q] <= wr_data0;
		end
		if (wr1) begin
			mem_q[wp_nx] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(n_wr);
			if (rd) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + n_wr - CW'(rd);
		end
	end

endmodule

>>> src/frms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed RMS volume front end
// Squares each sample, accumulates the open frame and issues jobs.
// ----------------------------------------------------------------------------
module frms_front #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_HOP     = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	input  logic                                   stream_start,
	input  logic                                   stream_end,
	input  logic [frms_pkg::HOP_BITS-1:0]          hop_q,
	output logic                                   wr0,
	output logic                                   wr1,
	output logic [frms_pkg::TAG_BITS+$clog2(MAX_HOP+1)
		+2*SAMPLE_BITS-1+$clog2(MAX_HOP)-1:0]      wr_data0,
	output logic [frms_pkg::TAG_BITS+$clog2(MAX_HOP+1)
		+2*SAMPLE_BITS-1+$clog2(MAX_HOP)-1:0]      wr_data1
);

	localparam int HW = $clog2(MAX_HOP + 1);
	localparam int SW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_HOP);
	localparam int QW = 2 * SAMPLE_BITS - 1;
	localparam int EW = frms_pkg::TAG_BITS + HW + SW;

	// Stage 1: magnitude and square.
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;
	logic [QW-1:0]          sq_s1;
	logic                   start_s1;
	logic                   end_s1;

	logic [SAMPLE_BITS-1:0] in_mag;
	logic [2*SAMPLE_BITS-1:0] in_sq;

	// Open frame accumulator.
	logic [SW-1:0] sum_q;
	logic [HW-1:0] cnt_q;

	logic [HW-1:0] hop_eff;
	logic [SW-1:0] new_sum;
	logic [HW-1:0] new_cnt;
	logic          close;

	frms_pkg::frms_job_tag_t mag_tag;
	frms_pkg::frms_job_tag_t frame_tag;
	logic [EW-1:0]           mag_job;
	logic [EW-1:0]           frame_job;

	always_comb begin
		in_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
		in_sq  = in_mag * in_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1   <= in_mag;
			sq_s1    <= in_sq[QW-1:0];
			start_s1 <= stream_start;
			end_s1   <= stream_end;
		end
	end

	always_comb begin
		if (hop_q < frms_pkg::HOP_BITS'(frms_pkg::MIN_HOP)) begin
			hop_eff = HW'(frms_pkg::MIN_HOP);
		end else if (32'(hop_q) > 32'(MAX_HOP)) begin
			hop_eff = HW'(MAX_HOP);
		end else begin
			hop_eff = HW'(hop_q);
		end
	end

	always_comb begin
		new_sum = (start_s1 ? '0 : sum_q) + SW'(sq_s1);
		new_cnt = (start_s1 ? '0 : cnt_q) + HW'(1);
		close   = (new_cnt >= hop_eff);
	end

	// A closed frame or a stream end leaves an empty frame behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (valid_s1) begin
			if (close || end_s1) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= new_sum;
				cnt_q <= new_cnt;
			end
		end
	end

	// The magnitude job goes first; it is the last result only when the
	// sample closes no frame.
	always_comb begin
		mag_tag.is_frame   = 1'b0;
		mag_tag.last       = !close;
		frame_tag.is_frame = 1'b1;
		frame_tag.last     = 1'b1;
		mag_job            = {mag_tag, HW'(0), SW'(mag_s1)};
		frame_job          = {frame_tag, hop_eff, new_sum};
	end

	assign wr0      = valid_s1 && (start_s1 || close);
	assign wr1      = valid_s1 && start_s1 && close;
	assign wr_data0 = start_s1 ? mag_job : frame_job;
	assign wr_data1 = frame_job;

endmodule

>>> src/frms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed RMS volume back end
// Divides a closed frame's sum by its hop and takes the integer square root,
// or passes a magnitude job on as it is, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module frms_back #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_HOP     = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [frms_pkg::TAG_BITS+$clog2(MAX_HOP+1)
		+2*SAMPLE_BITS-1+$clog2(MAX_HOP)-1:0] q_data,
	input  logic                         q_nonempty,
	output logic                         q_rd,
	input  logic                         pop,
	output logic                         empty,
	output logic [SAMPLE_BITS-1:0]       rms,
	output logic                         run_last
);

	localparam int HW = $clog2(MAX_HOP + 1);
	localparam int SW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_HOP);
	localparam int NQ = (SW + 1) / 2;
	localparam int RW = 2 * NQ;
	localparam int CW = $clog2(SW);
	localparam logic [SAMPLE_BITS-1:0] RMS_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_FIN
	} state_t;

	state_t                  state_q;
	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  rms_q;
	logic                    last_q;
	logic                    job_last_q;
	logic [CW-1:0]           step_q;
	logic [HW-1:0]           hop_q;
	logic [SW-1:0]           dvd_q;
	logic [HW-1:0]           rem_q;
	logic [RW-1:0]           rad_q;
	logic [NQ-1:0]           root_q;
	logic [NQ+1:0]           srem_q;

	frms_pkg::frms_job_tag_t job_tag;
	logic [HW-1:0]           job_hop;
	logic [SW-1:0]           job_val;
	logic                    out_free;
	logic                    out_load;

	logic [HW:0]             rem_sh;
	logic                    div_ge;
	logic [HW-1:0]           rem_nx;
	logic [SW-1:0]           dvd_nx;
	logic [NQ+1:0]           srem_sh;
	logic [NQ+1:0]           trial;
	logic                    sq_ge;
	logic [NQ+1:0]           srem_nx;
	logic [NQ-1:0]           root_nx;

	assign {job_tag, job_hop, job_val} = q_data;
	assign out_free = !out_valid_q || pop;
	assign q_rd     = (state_q == ST_IDLE) && q_nonempty && (job_tag.is_frame || out_free);
	assign out_load = (q_rd && !job_tag.is_frame) || ((state_q == ST_FIN) && out_free);
	assign empty    = !out_valid_q;
	assign rms      = rms_q;
	assign run_last = last_q;

	// One restoring division step: one quotient bit per cycle.
	always_comb begin
		rem_sh = {rem_q, dvd_q[SW-1]};
		div_ge = (rem_sh >= {1'b0, hop_q});
		rem_nx = div_ge ? HW'(rem_sh - {1'b0, hop_q}) : HW'(rem_sh);
		dvd_nx = {dvd_q[SW-2:0], div_ge};
	end

	// One square root step: one root bit per cycle.
	always_comb begin
		srem_sh = {srem_q[NQ-1:0], rad_q[RW-1 -: 2]};
		trial   = {root_q, 2'b01};
		sq_ge   = (srem_sh >= trial);
		srem_nx = sq_ge ? (srem_sh - trial) : srem_sh;
		root_nx = {root_q[NQ-2:0], sq_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !pop);
			unique case (state_q)
				ST_IDLE: begin
					if (q_rd) begin
						if (job_tag.is_frame) begin
							dvd_q      <= job_val;
							hop_q      <= job_hop;
							rem_q      <= '0;
							job_last_q <= job_tag.last;
							step_q     <= CW'(SW - 1);
							state_q    <= ST_DIV;
						end else begin
							rms_q  <= job_val[SAMPLE_BITS-1:0];
							last_q <= job_tag.last;
						end
					end
				end
				ST_DIV: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					if (step_q == '0) begin
						rad_q   <= RW'(dvd_nx);
						root_q  <= '0;
						srem_q  <= '0;
						step_q  <= CW'(NQ - 1);
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q - CW'(1);
					end
				end
				ST_SQRT: begin
					rad_q  <= rad_q << 2;
					root_q <= root_nx;
					srem_q <= srem_nx;
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q - CW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						rms_q   <= (root_q > NQ'(RMS_MAX)) ? RMS_MAX
							: root_q[SAMPLE_BITS-1:0];
						last_q  <= job_last_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/framed_rms_volume_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed RMS volume unit
// Frame RMS envelope of a stream of signed Q1.15 audio samples.
// ----------------------------------------------------------------------------
// The unit takes one audio sample per beat and gives one RMS volume value for
// every full, non-overlapping frame of hop_length samples: the integer square
// root of the frame's sum of squares divided by the hop, limited to 32768.
// A beat with stream_start set first gives the magnitude of that sample as a
// frame of its own and clears the open frame; a beat with stream_end set
// drops the partial frame that is left after it. run_last marks the last
// result that a sample causes. Samples are taken one per cycle as long as the
// job queue between the front and the back end has room. A sample that closes
// a frame costs the back end a serial divider pass and a serial square root
// pass, one bit per cycle each. A magnitude result goes straight from the job
// queue into the output register. hop_length is saturated to the range 128 to
// MAX_HOP and should be written only while no sample is in flight; cfg_ready
// is always high.
// ----------------------------------------------------------------------------
module framed_rms_volume_unit #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_HOP     = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample beats
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 stream_start,
	input  logic                                 stream_end,
	// result beats
	output logic                                 empty,
	input  logic                                 pop,
	output logic [SAMPLE_BITS-1:0]               rms,
	output logic                                 run_last,
	// hop length register write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [frms_pkg::HOP_BITS-1:0]        hop_length
);

	localparam int HW    = $clog2(MAX_HOP + 1);
	localparam int SW    = 2 * SAMPLE_BITS - 1 + $clog2(MAX_HOP);
	localparam int EW    = frms_pkg::TAG_BITS + HW + SW;
	localparam int DEPTH = frms_pkg::QUEUE_DEPTH;
	localparam int QCW   = $clog2(DEPTH + 1);

	logic [frms_pkg::HOP_BITS-1:0] hop_q;
	logic                          accept;
	logic                          wr0;
	logic                          wr1;
	logic [EW-1:0]                 wr_data0;
	logic [EW-1:0]                 wr_data1;
	logic                          q_rd;
	logic [EW-1:0]                 q_data;
	logic                          q_nonempty;
	logic [QCW-1:0]                q_count;

	// The register write is always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q <= frms_pkg::HOP_BITS'(frms_pkg::HOP_RESET);
		end else if (cfg_valid && cfg_ready) begin
			hop_q <= hop_length;
		end
	end

	// A new sample is taken only while the queue can still absorb the jobs of
	// the sample in the front pipeline and of the new one.
	assign full   = (q_count > QCW'(DEPTH - 2 * frms_pkg::JOBS_PER_SAMPLE));
	assign accept = push && !full;

	frms_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_HOP     (MAX_HOP)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample       (sample),
		.stream_start (stream_start),
		.stream_end   (stream_end),
		.hop_q        (hop_q),
		.wr0          (wr0),
		.wr1          (wr1),
		.wr_data0     (wr_data0),
		.wr_data1     (wr_data1)
	);

	frms_queue #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr0      (wr0),
		.wr1      (wr1),
		.wr_data0 (wr_data0),
		.wr_data1 (wr_data1),
		.rd       (q_rd),
		.rd_data  (q_data),
		.nonempty (q_nonempty),
		.count    (q_count)
	);

	frms_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_HOP     (MAX_HOP)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_data),
		.q_nonempty (q_nonempty),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.rms        (rms),
		.run_last   (run_last)
	);

endmodule
